### rtl/tfn_pkg.sv
// Shared types, pipeline constants and iteration step functions for the
// triangle flat-normal expander. No dependencies.
package tfn_pkg;

    localparam int SQ_STEPS = 22;
    localparam int SQ_PER   = 2;
    localparam int SQ_STG   = SQ_STEPS / SQ_PER;
    localparam int DV_STEPS = 15;
    localparam int DV_PER   = 3;
    localparam int DV_STG   = DV_STEPS / DV_PER;

    localparam logic [1:0]  LAST_CORNER = 2'd2;
    localparam logic [14:0] UNIT_Q14    = 15'd16384;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } t_vec24;

    typedef struct packed {
        t_vec24 p0;
        t_vec24 p1;
        t_vec24 p2;
    } t_pts;

    typedef struct packed {
        t_pts             pts;
        logic [2:0][15:0] m;
        logic [2:0]       neg;
        logic             degen;
    } t_pay;

    typedef struct packed {
        logic [25:0] rem;
        logic [21:0] root;
        logic [43:0] num;
    } t_sq;

    typedef struct packed {
        logic [23:0] rem;
        logic [14:0] lo;
        logic [14:0] q;
    } t_dv;

    function automatic t_sq sq_step(input t_sq s);
        t_sq         n;
        logic [25:0] trial;
        n.rem  = {s.rem[23:0], s.num[43:42]};
        n.num  = {s.num[41:0], 2'b00};
        trial  = {2'b00, s.root, 2'b01};
        if (n.rem >= trial) begin
            n.rem  = n.rem - trial;
            n.root = {s.root[20:0], 1'b1};
        end else begin
            n.root = {s.root[20:0], 1'b0};
        end
        return n;
    endfunction

    function automatic t_dv dv_step(input t_dv s, input logic [22:0] d);
        t_dv n;
        n.rem = {s.rem[22:0], s.lo[14]};
        n.lo  = {s.lo[13:0], 1'b0};
        if (n.rem >= {1'b0, d}) begin
            n.rem = n.rem - {1'b0, d};
            n.q   = {s.q[13:0], 1'b1};
        end else begin
            n.q   = {s.q[13:0], 1'b0};
        end
        return n;
    endfunction

endpackage

### rtl/tfn_core.sv
// Arithmetic pipeline: edge vectors, cross product, normalization, square
// root and per-component division. Uses tfn_pkg.
module tfn_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_ce,
    input  logic                   i_valid,
    input  tfn_pkg::t_pts          i_pts,
    output logic                   o_valid,
    output tfn_pkg::t_pts          o_pts,
    output logic [2:0][15:0]       o_nrm,
    output logic                   o_degen
);

    logic                     r1_v;
    tfn_pkg::t_pts            r1_pts;
    logic signed [2:0][24:0]  r1_a;
    logic signed [2:0][24:0]  r1_b;

    logic                     r2_v;
    tfn_pkg::t_pts            r2_pts;
    logic signed [5:0][49:0]  r2_p;

    logic                     r3_v;
    tfn_pkg::t_pts            r3_pts;
    logic [2:0][49:0]         r3_mag;
    logic [2:0]               r3_neg;

    logic                     r4_v;
    tfn_pkg::t_pts            r4_pts;
    logic [2:0][49:0]         r4_mag;
    logic [2:0]               r4_neg;
    logic [5:0]               r4_len;
    logic                     r4_degen;

    logic                     r5_v;
    tfn_pkg::t_pay            r5_pay;

    logic                     r6_v;
    tfn_pkg::t_pay            r6_pay;
    logic [2:0][31:0]         r6_sq;

    logic                     r_sq_v   [0:tfn_pkg::SQ_STG];
    tfn_pkg::t_pay            r_sq_pay [0:tfn_pkg::SQ_STG];
    tfn_pkg::t_sq             r_sq     [0:tfn_pkg::SQ_STG];

    logic                     r_dv_v   [0:tfn_pkg::DV_STG];
    tfn_pkg::t_pay            r_dv_pay [0:tfn_pkg::DV_STG];
    logic [22:0]              r_dv_d   [0:tfn_pkg::DV_STG];
    tfn_pkg::t_dv             r_dv     [0:tfn_pkg::DV_STG][0:2];

    logic                     r_o_v;
    tfn_pkg::t_pts            r_o_pts;
    logic [2:0][15:0]         r_o_nrm;
    logic                     r_o_degen;

    logic signed [2:0][50:0]  w_c;
    logic [2:0][50:0]         w_abs;
    logic [49:0]              w_or;
    logic [5:0]               n_len;
    logic [2:0][15:0]         w_m;
    logic [33:0]              w_s;
    logic [35:0]              w_num [0:2];
    logic [2:0][15:0]         n_nrm;

    always_comb begin
        w_c[0] = {r2_p[0][49], r2_p[0]} - {r2_p[1][49], r2_p[1]};
        w_c[1] = {r2_p[2][49], r2_p[2]} - {r2_p[3][49], r2_p[3]};
        w_c[2] = {r2_p[4][49], r2_p[4]} - {r2_p[5][49], r2_p[5]};
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = w_c[i][50] ? -w_c[i] : w_c[i];
        end
        w_or  = r3_mag[0] | r3_mag[1] | r3_mag[2];
        n_len = '0;
        for (int k = 0; k < 50; k++) begin
            if (w_or[k]) begin
                n_len = 6'(k + 1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (r4_len > 6'd16) begin
                w_m[i] = 16'(r4_mag[i] >> (r4_len - 6'd16));
            end else begin
                w_m[i] = 16'(r4_mag[i] << (6'd16 - r4_len));
            end
        end
        w_s = 34'(r6_sq[0]) + 34'(r6_sq[1]) + 34'(r6_sq[2]);
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {1'b0, r_sq_pay[tfn_pkg::SQ_STG].m[i], 19'b0}
                     + {14'b0, r_sq[tfn_pkg::SQ_STG].root};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r_sq_v[0] <= 1'b0;
            r_dv_v[0] <= 1'b0;
            r_o_v <= 1'b0;
        end else if (i_ce) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r_sq_v[0] <= r6_v;
            r_dv_v[0] <= r_sq_v[tfn_pkg::SQ_STG];
            r_o_v <= r_dv_v[tfn_pkg::DV_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_pts  <= i_pts;
            r1_a[0] <= 25'(i_pts.p2.x) - 25'(i_pts.p1.x);
            r1_a[1] <= 25'(i_pts.p2.y) - 25'(i_pts.p1.y);
            r1_a[2] <= 25'(i_pts.p2.z) - 25'(i_pts.p1.z);
            r1_b[0] <= 25'(i_pts.p0.x) - 25'(i_pts.p1.x);
            r1_b[1] <= 25'(i_pts.p0.y) - 25'(i_pts.p1.y);
            r1_b[2] <= 25'(i_pts.p0.z) - 25'(i_pts.p1.z);

            r2_pts  <= r1_pts;
            r2_p[0] <= $signed(r1_a[1]) * $signed(r1_b[2]);
            r2_p[1] <= $signed(r1_a[2]) * $signed(r1_b[1]);
            r2_p[2] <= $signed(r1_a[2]) * $signed(r1_b[0]);
            r2_p[3] <= $signed(r1_a[0]) * $signed(r1_b[2]);
            r2_p[4] <= $signed(r1_a[0]) * $signed(r1_b[1]);
            r2_p[5] <= $signed(r1_a[1]) * $signed(r1_b[0]);

            r3_pts <= r2_pts;
            for (int i = 0; i < 3; i++) begin
                r3_mag[i] <= w_abs[i][49:0];
                r3_neg[i] <= w_c[i][50];
            end

            r4_pts   <= r3_pts;
            r4_mag   <= r3_mag;
            r4_neg   <= r3_neg;
            r4_len   <= n_len;
            r4_degen <= (w_or == '0);

            r5_pay.pts   <= r4_pts;
            r5_pay.m     <= w_m;
            r5_pay.neg   <= r4_neg;
            r5_pay.degen <= r4_degen;

            r6_pay <= r5_pay;
            for (int i = 0; i < 3; i++) begin
                r6_sq[i] <= r5_pay.m[i] * r5_pay.m[i];
            end

            r_sq_pay[0] <= r6_pay;
            r_sq[0].rem  <= '0;
            r_sq[0].root <= '0;
            r_sq[0].num  <= {2'b00, w_s, 8'b0};

            r_dv_pay[0] <= r_sq_pay[tfn_pkg::SQ_STG];
            r_dv_d[0]   <= {r_sq[tfn_pkg::SQ_STG].root, 1'b0};
            for (int i = 0; i < 3; i++) begin
                r_dv[0][i].rem <= {3'b000, w_num[i][35:15]};
                r_dv[0][i].lo  <= w_num[i][14:0];
                r_dv[0][i].q   <= '0;
            end

            r_o_pts   <= r_dv_pay[tfn_pkg::DV_STG].pts;
            r_o_nrm   <= n_nrm;
            r_o_degen <= r_dv_pay[tfn_pkg::DV_STG].degen;
        end
    end

    for (genvar k = 0; k < tfn_pkg::SQ_STG; k++) begin : g_sq
        tfn_pkg::t_sq n_sq;
        always_comb begin
            n_sq = r_sq[k];
            for (int j = 0; j < tfn_pkg::SQ_PER; j++) begin
                n_sq = tfn_pkg::sq_step(n_sq);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (i_ce) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_sq[k+1]     <= n_sq;
                r_sq_pay[k+1] <= r_sq_pay[k];
            end
        end
    end

    for (genvar k = 0; k < tfn_pkg::DV_STG; k++) begin : g_dv
        for (genvar i = 0; i < 3; i++) begin : g_cmp
            tfn_pkg::t_dv n_dv;
            always_comb begin
                n_dv = r_dv[k][i];
                for (int j = 0; j < tfn_pkg::DV_PER; j++) begin
                    n_dv = tfn_pkg::dv_step(n_dv, r_dv_d[k]);
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_dv[k+1][i] <= n_dv;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (i_ce) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_dv_pay[k+1] <= r_dv_pay[k];
                r_dv_d[k+1]   <= r_dv_d[k];
            end
        end
    end

    always_comb begin
        logic [14:0] mag;
        for (int i = 0; i < 3; i++) begin
            mag = r_dv[tfn_pkg::DV_STG][i].q;
            if (mag > tfn_pkg::UNIT_Q14) begin
                mag = tfn_pkg::UNIT_Q14;
            end
            if (r_dv_pay[tfn_pkg::DV_STG].degen) begin
                n_nrm[i] = '0;
            end else if (r_dv_pay[tfn_pkg::DV_STG].neg[i]) begin
                n_nrm[i] = -{1'b0, mag};
            end else begin
                n_nrm[i] = {1'b0, mag};
            end
        end
    end

    assign o_valid = r_o_v;
    assign o_pts   = r_o_pts;
    assign o_nrm   = r_o_nrm;
    assign o_degen = r_o_degen;

endmodule

### rtl/triangle_flat_normal_expander.sv
// Top level of the triangle flat-normal expander: arithmetic pipeline plus
// the three-beat output serializer. Uses tfn_pkg and tfn_core.
//
// Usage: the input channel (i_valid / o_ready) takes one triangle per beat
// as three Q7.16 corners. The output channel (o_valid / i_ready) gives
// three beats per triangle in corner order, each with that corner's
// position, the shared Q1.14 unit normal and the degenerate flag; the
// third beat has o_last_corner set.
// The whole arithmetic pipeline advances on one enable, so a new triangle
// may enter every cycle while the serializer is empty or sending its last
// beat; sustained throughput is set by the three output beats per triangle.
// Reset (synchronous, active low) clears all valid bits and the
// serializer. When the receiver stalls the pipeline freezes in place and
// o_ready drops; no beat is lost or repeated.
module triangle_flat_normal_expander (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [23:0] i_corner0_x,
    input  logic signed [23:0] i_corner0_y,
    input  logic signed [23:0] i_corner0_z,
    input  logic signed [23:0] i_corner1_x,
    input  logic signed [23:0] i_corner1_y,
    input  logic signed [23:0] i_corner1_z,
    input  logic signed [23:0] i_corner2_x,
    input  logic signed [23:0] i_corner2_y,
    input  logic signed [23:0] i_corner2_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_position_x,
    output logic signed [23:0] o_position_y,
    output logic signed [23:0] o_position_z,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic               o_degenerate,
    output logic               o_last_corner
);

    tfn_pkg::t_pts    w_in_pts;
    logic             w_ce;
    logic             w_last_take;
    logic             w_core_v;
    tfn_pkg::t_pts    w_core_pts;
    logic [2:0][15:0] w_core_nrm;
    logic             w_core_degen;

    logic             r_busy;
    logic [1:0]       r_cnt;
    tfn_pkg::t_pts    r_pts;
    logic [2:0][15:0] r_nrm;
    logic             r_degen;
    tfn_pkg::t_vec24  w_pos;

    assign w_in_pts.p0 = '{x: i_corner0_x, y: i_corner0_y, z: i_corner0_z};
    assign w_in_pts.p1 = '{x: i_corner1_x, y: i_corner1_y, z: i_corner1_z};
    assign w_in_pts.p2 = '{x: i_corner2_x, y: i_corner2_y, z: i_corner2_z};

    assign w_last_take = r_busy && i_ready && (r_cnt == tfn_pkg::LAST_CORNER);
    assign w_ce        = !r_busy || w_last_take;
    assign o_ready     = w_ce;

    tfn_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_valid),
        .i_pts   (w_in_pts),
        .o_valid (w_core_v),
        .o_pts   (w_core_pts),
        .o_nrm   (w_core_nrm),
        .o_degen (w_core_degen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_ce && w_core_v) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_last_take) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy && i_ready) begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce && w_core_v) begin
            r_pts   <= w_core_pts;
            r_nrm   <= w_core_nrm;
            r_degen <= w_core_degen;
        end
    end

    always_comb begin
        unique case (r_cnt)
            2'd0:    w_pos = r_pts.p0;
            2'd1:    w_pos = r_pts.p1;
            default: w_pos = r_pts.p2;
        endcase
    end

    assign o_valid       = r_busy;
    assign o_position_x  = w_pos.x;
    assign o_position_y  = w_pos.y;
    assign o_position_z  = w_pos.z;
    assign o_normal_x    = r_nrm[0];
    assign o_normal_y    = r_nrm[1];
    assign o_normal_z    = r_nrm[2];
    assign o_degenerate  = r_degen;
    assign o_last_corner = (r_cnt == tfn_pkg::LAST_CORNER);

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_normal_x == 16'sd0 && o_normal_y == 16'sd0
            && o_normal_z == 16'sd0)
        else $error("Degenerate beat carries a nonzero normal.");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384
            && o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384
            && o_normal_z <= 16'sd16384 && o_normal_z >= -16'sd16384)
        else $error("Normal component exceeds unit magnitude.");

    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_corner |=> o_valid && r_cnt == $past(r_cnt) + 2'd1)
        else $error("Corner beats out of order.");

endmodule

### test/tfn_checker.sv
// Checker for the triangle flat-normal expander: watches both channels,
// predicts the three vertex beats of every triangle and compares them.
// Depends on nothing but the ports of the block.
`timescale 1ns / 100ps
module tfn_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [23:0] c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [23:0] px, py, pz,
    input  logic signed [15:0] nx, ny, nz,
    input  logic               degen,
    input  logic               last,
    output int                 errors,
    output int                 pending
);
    typedef struct packed {
        logic [23:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic        degen;
        logic        last;
    } t_vertex;

    t_vertex exp_mem [256];
    int      wr_cnt;
    int      rd_cnt;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    task automatic push_triangle(input logic signed [23:0] p[9]);
        longint a[3], b[3], c[3];
        logic [63:0] mag[3], m, s, r, q;
        logic [15:0] nrm[3];
        int len;
        t_vertex v;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'(p[6 + i]) - longint'(p[3 + i]);
            b[i] = longint'(p[i]) - longint'(p[3 + i]);
        end
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? -c[i] : c[i];
            if (mag[i] > m) m = mag[i];
            nrm[i] = 0;
        end
        if (m != 0) begin
            len = 0;
            while ((m >> len) != 0) len++;
            for (int i = 0; i < 3; i++) begin
                if (len > 16) mag[i] = mag[i] >> (len - 16);
                else if (len < 16) mag[i] = mag[i] << (16 - len);
            end
            s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            r = int_sqrt(s << 8);
            for (int i = 0; i < 3; i++) begin
                q = ((mag[i] << 19) + r) / (2 * r);
                if (q > 16384) q = 16384;
                nrm[i] = c[i] < 0 ? 16'(-q) : 16'(q);
            end
        end
        for (int k = 0; k < 3; k++) begin
            v.px = p[3 * k];
            v.py = p[3 * k + 1];
            v.pz = p[3 * k + 2];
            v.nx = nrm[0];
            v.ny = nrm[1];
            v.nz = nrm[2];
            v.degen = (m == 0);
            v.last = (k == 2);
            if (wr_cnt - rd_cnt >= 256) begin
                $display("%0t: expected beat store overflow", $time);
                errors++;
            end
            exp_mem[wr_cnt % 256] = v;
            wr_cnt++;
        end
    endtask

    initial begin
        errors = 0;
        wr_cnt = 0;
        rd_cnt = 0;
    end
    assign pending = wr_cnt - rd_cnt;

    always @(posedge i_clk) begin
        logic signed [23:0] p[9];
        t_vertex got, exp_v;
        if (i_rst_n && in_valid && in_ready) begin
            p = '{c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z};
            push_triangle(p);
        end
        if (i_rst_n && out_valid && out_ready) begin
            got = '{px, py, pz, nx, ny, nz, degen, last};
            if (wr_cnt == rd_cnt) begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
            end else begin
                exp_v = exp_mem[rd_cnt % 256];
                rd_cnt++;
                if (got != exp_v) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_v, got);
                    errors++;
                end
            end
        end
    end
endmodule

### test/tb_triangle_flat_normal_expander.sv
// Testbench top for the triangle flat-normal expander: drives triangles
// with random gaps and stalls and gives the verdict. Uses tfn_checker.
`timescale 1ns / 100ps
module tb_triangle_flat_normal_expander;
    logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
    logic signed [23:0] c[9];
    logic signed [23:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic degen, last;
    int errors, pending, send_idle, recv_stall, idle_cnt;
    bit hold_off;

    triangle_flat_normal_expander uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_corner0_x(c[0]), .i_corner0_y(c[1]), .i_corner0_z(c[2]),
        .i_corner1_x(c[3]), .i_corner1_y(c[4]), .i_corner1_z(c[5]),
        .i_corner2_x(c[6]), .i_corner2_y(c[7]), .i_corner2_z(c[8]),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_position_x(px), .o_position_y(py), .o_position_z(pz),
        .o_normal_x(nx), .o_normal_y(ny), .o_normal_z(nz),
        .o_degenerate(degen), .o_last_corner(last)
    );

    tfn_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .c0x(c[0]), .c0y(c[1]), .c0z(c[2]), .c1x(c[3]), .c1y(c[4]), .c1z(c[5]),
        .c2x(c[6]), .c2y(c[7]), .c2z(c[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .px(px), .py(py), .pz(pz), .nx(nx), .ny(ny), .nz(nz),
        .degen(degen), .last(last), .errors(errors), .pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'(int'($urandom_range(0, 64)) - 32);
            3: return 24'($urandom_range(0, 2047)) << $urandom_range(0, 12);
            default: return 24'($urandom);
        endcase
    endfunction

    always @(negedge clk) begin
        out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 5000) begin
            $display("tb_triangle_flat_normal_expander failed");
            $finish;
        end
    end

    task automatic send(input logic [23:0] v[9]);
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
            in_valid <= 0;
            @(negedge clk);
        end
        for (int i = 0; i < 9; i++) c[i] <= v[i];
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_directed(input int kind);
        logic [23:0] v[9];
        for (int i = 0; i < 9; i++) v[i] = rand_coord();
        case (kind)
            0: foreach (v[i]) v[i] = 24'h7fffff;
            1: foreach (v[i]) v[i] = 24'h800000;
            2: v = '{24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff,
                     24'h800000, 24'h800000, 24'h800000, 24'h7fffff};
            3: v = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
            4: v = '{24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0};
            5: v = '{24'd3, 24'd3, 24'd3, 24'd1, 24'd1, 24'd1, 24'd2, 24'd2, 24'd2};
            6: v = '{24'h10000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
                     24'h10000, 24'h10000};
            7: v = '{24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
                     24'h0, 24'hffffff};
            8: for (int i = 0; i < 3; i++) v[6 + i] = v[i];
            default: ;
        endcase
        send(v);
    endtask

    initial begin
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        hold_off = 0;
        send_idle = 0;
        recv_stall = 0;
        idle_cnt = 0;
        foreach (c[i]) c[i] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        for (int k = 0; k < 20; k++) send_directed(k);
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            begin
                for (int k = 0; k < 40; k++) send_directed(99);
                in_valid <= 0;
            end
        join
        @(negedge clk);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1) ? 69 : (ph == 3) ? 30 : 0;
            recv_stall = (ph == 2) ? 69 : (ph == 3) ? 30 : 0;
            for (int k = 0; k < 105; k++) send_directed(k % 25 == 0 ? k % 10 : 99);
        end
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0) $display("tb_triangle_flat_normal_expander passed");
        else $display("tb_triangle_flat_normal_expander failed");
        $finish;
    end
endmodule
